// ===== rtl/vnorm_pkg.sv =====
// Package for the 2D/3D vector normalizer: widths, stage counts and shared types.
// No dependencies; used by vector_normalize_2d_3d.
`timescale 1ns / 1ps
package vnorm_pkg;

  localparam int CW     = 32;          // component width
  localparam int FB     = 16;          // fraction bits
  localparam int SQ_W   = 2 * CW;      // squared length width
  localparam int QW     = FB + 2;      // quotient bits, magnitude below 2 << FB
  localparam int REM_W  = CW + 2;      // square root remainder width
  localparam int TOL_W  = 48;          // threshold register width
  localparam int APB_DW = 64;
  localparam int APB_AW = 4;

  localparam logic [APB_AW-1:0] ADDR_MIN_SQ = 4'h0;

  typedef struct packed {
    logic [CW-1:0] mx;
    logic [CW-1:0] my;
    logic [CW-1:0] mz;
    logic          nx;
    logic          ny;
    logic          nz;
    logic          planar;
    logic          short_vec;
  } side_t;

  function automatic logic [CW-1:0] apply_sign(input logic [CW-1:0] mag, input logic neg);
    apply_sign = neg ? (~mag + {{(CW-1){1'b0}}, 1'b1}) : mag;
  endfunction

endpackage

// ===== rtl/vector_normalize_2d_3d.sv =====
// Top level of the 2D/3D vector normalizer: squares, pipelined square root,
// pipelined dividers and the threshold register. Depends on vnorm_pkg.
`timescale 1ns / 1ps
// The block takes one vector beat per cycle (signed Q16.16 x, y, z and a planar
// flag) and returns one result beat per input beat, in order: the normalized
// components, the floor square root of the exact squared length, and a status
// bit that is set when the squared length is zero or below min_squared_length,
// in which case the components are copied through unchanged. In planar mode z
// is left out of the length and passed through. Throughput is one vector per
// cycle while the output is not stalled. The stages are four front stages
// (magnitudes, squares, sum, threshold test), the square root (one result bit
// per stage, 32 stages), the three dividers running side by side (one quotient
// bit per stage, 18 stages) and the output register. The whole pipeline
// advances together and freezes only while a finished result sits at the
// output under stall, so in_stall follows out_stall of a valid output beat.
// The threshold is written through the APB port at byte address 0 as a
// 64-bit word (low 48 bits kept).
module vector_normalize_2d_3d (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [vnorm_pkg::APB_AW-1:0] paddr,
  input  logic [vnorm_pkg::APB_DW-1:0] pwdata,
  output logic [vnorm_pkg::APB_DW-1:0] prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [31:0]           x_in,
  input  logic signed [31:0]           y_in,
  input  logic signed [31:0]           z_in,
  input  logic                         planar,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [31:0]           x_out,
  output logic signed [31:0]           y_out,
  output logic signed [31:0]           z_out,
  output logic [31:0]                  length,
  output logic                         status
);
  import vnorm_pkg::*;

  // Threshold register. The user must make writes only while the pipeline is idle; the block does not enforce it.
  logic [TOL_W-1:0] min_squared_length;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_squared_length <= {{(TOL_W-1){1'b0}}, 1'b1};
    end else if (psel && penable && pwrite && paddr == ADDR_MIN_SQ) begin
      min_squared_length <= pwdata[TOL_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_MIN_SQ) begin
      prdata = {{(APB_DW-TOL_W){1'b0}}, min_squared_length};
    end
  end

  // One enable for all stages: move unless a valid result is held at the output.
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Stage 0: magnitudes and signs.
  logic  v0;
  side_t side0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side0.nx        <= x_in[CW-1];
      side0.ny        <= y_in[CW-1];
      side0.nz        <= z_in[CW-1];
      side0.mx        <= apply_sign(x_in[CW-1:0], x_in[CW-1]);
      side0.my        <= apply_sign(y_in[CW-1:0], y_in[CW-1]);
      side0.mz        <= apply_sign(z_in[CW-1:0], z_in[CW-1]);
      side0.planar    <= planar;
      side0.short_vec <= 1'b0;
    end
  end

  // Stage 1: the three squares, one multiplier each.
  logic            v1;
  side_t           side1;
  logic [SQ_W-1:0] sqx, sqy, sqz;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1 <= side0;
      sqx   <= side0.mx * side0.mx;
      sqy   <= side0.my * side0.my;
      sqz   <= side0.planar ? '0 : side0.mz * side0.mz;
    end
  end

  // Stage 2: squared length. The sum cannot overflow 64 bits.
  logic            v2;
  side_t           side2;
  logic [SQ_W-1:0] sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side2 <= side1;
      sq    <= sqx + sqy + sqz;
    end
  end

  // Stage 3: threshold test, kept apart from the adder.
  logic            v3;
  side_t           side3;
  side_t           side3_next;
  logic [SQ_W-1:0] sq3;

  always_comb begin
    side3_next           = side2;
    side3_next.short_vec = (sq == '0) ||
                           (sq < {{(SQ_W-TOL_W){1'b0}}, min_squared_length});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side3 <= side3_next;
      sq3   <= sq;
    end
  end

  // Square root, one result bit per stage. Entry 0 of each array is the feed.
  logic             sv   [CW+1];
  side_t            sside[CW+1];
  logic [SQ_W-1:0]  sn   [CW+1];
  logic [REM_W-1:0] srem [CW+1];
  logic [CW-1:0]    sroot[CW+1];

  assign sv[0]    = v3;
  assign sside[0] = side3;
  assign sn[0]    = sq3;
  assign srem[0]  = '0;
  assign sroot[0] = '0;

  for (genvar r = 0; r < CW; r++) begin : g_sqrt
    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] trial;
    logic             ge;

    assign cur   = {srem[r][REM_W-3:0], sn[r][SQ_W-1:SQ_W-2]};
    assign trial = {sroot[r], 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[r+1] <= 1'b0;
      end else if (en) begin
        sv[r+1] <= sv[r];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sside[r+1] <= sside[r];
        sn[r+1]    <= {sn[r][SQ_W-3:0], 2'b00};
        srem[r+1]  <= ge ? cur - trial : cur;
        sroot[r+1] <= {sroot[r][CW-2:0], ge};
      end
    end
  end

  // Dividers: (|c| << FB) / length, one quotient bit per stage for x, y and z.
  // The quotient fits QW bits, so the partial remainder starts at the dividend's
  // upper bits, which are already below the divisor.
  logic          dv   [QW+1];
  side_t         dside[QW+1];
  logic [CW-1:0] dlen [QW+1];
  logic [CW-1:0] drem [3][QW+1];
  logic [QW-1:0] dlo  [3][QW+1];
  logic [QW-1:0] dq   [3][QW+1];
  logic [CW-1:0] dmag [3];

  assign dv[0]    = sv[CW];
  assign dside[0] = sside[CW];
  assign dlen[0]  = sroot[CW];
  assign dmag[0]  = sside[CW].mx;
  assign dmag[1]  = sside[CW].my;
  assign dmag[2]  = sside[CW].mz;

  for (genvar c = 0; c < 3; c++) begin : g_feed
    assign drem[c][0] = dmag[c] >> (QW - FB);
    assign dlo[c][0]  = {dmag[c][QW-FB-1:0], {FB{1'b0}}};
    assign dq[c][0]   = '0;
  end

  for (genvar d = 0; d < QW; d++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[d+1] <= 1'b0;
      end else if (en) begin
        dv[d+1] <= dv[d];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dside[d+1] <= dside[d];
        dlen[d+1]  <= dlen[d];
      end
    end

    for (genvar c = 0; c < 3; c++) begin : g_lane
      logic [CW:0] cur;
      logic        ge;

      assign cur = {drem[c][d], dlo[c][d][QW-1]};
      assign ge  = cur >= {1'b0, dlen[d]};

      always_ff @(posedge clk) begin
        if (en) begin
          drem[c][d+1] <= ge ? CW'(cur - {1'b0, dlen[d]}) : cur[CW-1:0];
          dlo[c][d+1]  <= {dlo[c][d][QW-2:0], 1'b0};
          dq[c][d+1]   <= {dq[c][d][QW-2:0], ge};
        end
      end
    end
  end

  // Output register: pick quotient or copied component and restore signs.
  side_t         fs;
  logic [CW-1:0] qx, qy, qz;

  assign fs = dside[QW];
  assign qx = CW'(dq[0][QW]);
  assign qy = CW'(dq[1][QW]);
  assign qz = CW'(dq[2][QW]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      length <= dlen[QW];
      status <= fs.short_vec;
      x_out  <= apply_sign(fs.short_vec ? fs.mx : qx, fs.nx);
      y_out  <= apply_sign(fs.short_vec ? fs.my : qy, fs.ny);
      z_out  <= apply_sign((fs.short_vec || fs.planar) ? fs.mz : qz, fs.nz);
    end
  end

  // A normalized result always comes from a nonzero length.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !status |-> length != '0)
    else $error("normalized result with zero length");

  // Normalized x stays within two units.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !status |-> (x_out <= (32'sd2 <<< FB)) && (x_out >= -(32'sd2 <<< FB)))
    else $error("normalized x out of range");

  // A held output beat freezes the input side in the same cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow held output");

  // A beat under stall keeps its status and length.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(length))
    else $error("held output beat changed");

endmodule
